// ----- hw/rtl/ats_pkg.sv -----
// Package for the ancestry tract segmenter.
// Holds the beat structs, the per-sample tract entry, opcodes and constants.
// No dependencies.
package ats_pkg;

    localparam int unsigned SAMPLES_DEF = 256;
    localparam int unsigned SAMPLE_W    = 8;
    localparam int unsigned POS_W       = 32;
    localparam int unsigned LABEL_W     = 8;
    localparam int unsigned CHROM_W     = 8;

    localparam logic [1:0] OP_CONT  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam logic [LABEL_W-1:0] NO_LABEL = 8'hFF;

    typedef struct packed {
        logic [1:0]          op;
        logic [SAMPLE_W-1:0] sample;
        logic [POS_W-1:0]    pos;
        logic [LABEL_W-1:0]  anc_first;
        logic [LABEL_W-1:0]  anc_second;
        logic [CHROM_W-1:0]  chrom_id;
        logic                record_end;
    } t_in_beat;

    typedef struct packed {
        logic [SAMPLE_W-1:0] out_sample;
        logic [CHROM_W-1:0]  out_chrom;
        logic [POS_W-1:0]    start_pos;
        logic [POS_W-1:0]    end_pos;
        logic [LABEL_W-1:0]  out_anc_first;
        logic [LABEL_W-1:0]  out_anc_second;
    } t_out_beat;

    typedef struct packed {
        logic [LABEL_W-1:0] anc_first;
        logic [LABEL_W-1:0] anc_second;
        logic [POS_W-1:0]   start;
        logic [CHROM_W-1:0] chrom;
    } t_tract_entry;

    typedef struct packed {
        logic         emit;
        logic         wr_en;
        logic         last_wr;
        t_tract_entry wr_entry;
        t_out_beat    beat;
    } t_upd_res;

    localparam t_tract_entry ENTRY_RST = '{
        anc_first:  NO_LABEL,
        anc_second: NO_LABEL,
        start:      '0,
        chrom:      '0
    };

endpackage

// ----- hw/rtl/ats_tract_mem.sv -----
// Per-sample tract store: one write port, one registered read port.
// Runs a clearing pass over every entry after reset. Uses ats_pkg.
module ats_tract_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output ats_pkg::t_tract_entry o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  ats_pkg::t_tract_entry i_wr_data,
    output logic                 o_clr_busy
);
    import ats_pkg::*;

    t_tract_entry mem [DEPTH];
    t_tract_entry r_rd_data;
    logic         r_clr_busy;
    logic [AW-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_idx] <= ENTRY_RST;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

// ----- hw/rtl/ats_tract_update.sv -----
// Tract update logic: decides the emitted tract and the new entry for one beat.
// Purely combinational. Uses ats_pkg.
module ats_tract_update #(
    parameter int unsigned SAMPLES = 256
) (
    input  ats_pkg::t_in_beat     i_beat,
    input  ats_pkg::t_tract_entry i_entry,
    input  logic [31:0]           i_last_pos,
    output ats_pkg::t_upd_res     o_res
);
    import ats_pkg::*;

    logic              in_range;
    logic              held_open;
    logic              pair_chg;
    logic [POS_W-1:0]  delta;
    logic [POS_W-1:0]  mid;
    logic [POS_W-1:0]  end_pos;

    always_comb begin
        in_range  = (17'(i_beat.sample) < 17'(SAMPLES));
        held_open = (i_entry.anc_first != NO_LABEL) || (i_entry.anc_second != NO_LABEL);
        pair_chg  = (i_beat.anc_first != i_entry.anc_first)
                 || (i_beat.anc_second != i_entry.anc_second);
        delta     = i_beat.pos - i_last_pos;
        mid       = i_last_pos + {1'b0, delta[POS_W-1:1]};

        o_res          = '0;
        o_res.wr_entry = i_entry;
        end_pos        = i_last_pos;

        case (i_beat.op)
            OP_CONT: begin
                o_res.last_wr = i_beat.record_end;
                if (in_range && pair_chg) begin
                    o_res.emit                = 1'b1;
                    o_res.wr_en               = 1'b1;
                    end_pos                   = mid;
                    o_res.wr_entry.anc_first  = i_beat.anc_first;
                    o_res.wr_entry.anc_second = i_beat.anc_second;
                    o_res.wr_entry.start      = mid + 1'b1;
                end
            end
            OP_START: begin
                o_res.last_wr = i_beat.record_end;
                if (in_range) begin
                    o_res.emit                = held_open;
                    o_res.wr_en               = 1'b1;
                    end_pos                   = i_beat.pos - 1'b1;
                    o_res.wr_entry.anc_first  = i_beat.anc_first;
                    o_res.wr_entry.anc_second = i_beat.anc_second;
                    o_res.wr_entry.start      = i_beat.pos;
                    o_res.wr_entry.chrom      = i_beat.chrom_id;
                end
            end
            OP_FLUSH: begin
                if (in_range && held_open) begin
                    o_res.emit                = 1'b1;
                    o_res.wr_en               = 1'b1;
                    o_res.wr_entry.anc_first  = NO_LABEL;
                    o_res.wr_entry.anc_second = NO_LABEL;
                end
            end
            default: begin
            end
        endcase

        o_res.beat.out_sample     = i_beat.sample;
        o_res.beat.out_chrom      = i_entry.chrom;
        o_res.beat.start_pos      = i_entry.start;
        o_res.beat.end_pos        = end_pos;
        o_res.beat.out_anc_first  = i_entry.anc_first;
        o_res.beat.out_anc_second = i_entry.anc_second;
    end

endmodule

// ----- hw/rtl/ancestry_tract_segmenter_core.sv -----
// Ancestry tract segmenter top level.
// Depends on ats_pkg, ats_tract_mem and ats_tract_update.
//
// Input channel i_in_valid / o_in_stall carries one sample's label pair per
// beat; output channel o_out_valid / i_out_stall carries closed tracts.
// A beat yields zero or one tract. The accepted beat is registered in the
// update stage and its tract in the result register that drives o_out_valid.
// Throughput is one beat per cycle unless the reset sweep or an output stall
// holds the input: the per-sample entry is read at acceptance, updated in the
// update stage and written back, bypassed for back-to-back same-sample beats.
// After reset the tract store is swept once, one entry per cycle, over all
// min(SAMPLES, 256) entries; o_in_stall stays high during the sweep.
// When i_out_stall is high the result register holds its beat; one more beat
// with a tract may wait in the update stage, after which o_in_stall rises.
module ancestry_tract_segmenter_core #(
    parameter int unsigned SAMPLES = ats_pkg::SAMPLES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ats_pkg::t_in_beat   i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ats_pkg::t_out_beat  o_out_beat
);
    import ats_pkg::*;

    localparam int unsigned DEPTH = (SAMPLES < 256) ? SAMPLES : 256;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          accept;
    logic          clr_busy;
    logic          can_out;
    logic          s1_done;
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    t_tract_entry  rd_data;
    t_tract_entry  cur_entry;
    t_upd_res      upd;

    logic          r_s1_vld;
    t_in_beat      r_s1_beat;
    logic          r_fwd_hit;
    t_tract_entry  r_fwd_entry;
    logic [31:0]   r_last_pos;
    logic          r_out_vld;
    t_out_beat     r_out_beat;

    assign rd_addr   = i_in_beat.sample[AW-1:0];
    assign wr_addr   = r_s1_beat.sample[AW-1:0];
    assign cur_entry = r_fwd_hit ? r_fwd_entry : rd_data;
    assign can_out   = !r_out_vld || !i_out_stall;
    assign s1_done   = r_s1_vld && (!upd.emit || can_out);
    assign wr_en     = s1_done && upd.wr_en;
    assign o_in_stall = clr_busy || (r_s1_vld && !s1_done);
    assign accept    = i_in_valid && !o_in_stall;

    ats_tract_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (upd.wr_entry),
        .o_clr_busy (clr_busy)
    );

    ats_tract_update #(
        .SAMPLES (SAMPLES)
    ) u_upd (
        .i_beat     (r_s1_beat),
        .i_entry    (cur_entry),
        .i_last_pos (r_last_pos),
        .o_res      (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_last_pos <= '0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_done) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_done && upd.emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (s1_done && upd.last_wr) begin
                r_last_pos <= r_s1_beat.pos;
            end
        end
    end

    // bypass the entry being written at the same edge a new beat reads it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_beat   <= i_in_beat;
            r_fwd_hit   <= wr_en && (wr_addr == rd_addr);
            r_fwd_entry <= upd.wr_entry;
        end
        if (s1_done && upd.emit) begin
            r_out_beat <= upd.beat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out_beat;

endmodule
